FILE: rtl/lmnf_pkg.sv
`timescale 1ns / 1ps
// Package for the list marker numeral formatter.
// Holds the job record passed from front to back, character codes and
// the Roman numeral helper functions. No dependencies.
package lmnf_pkg;

  // marker styles on the input
  localparam logic [3:0] STYLE_DISC        = 4'd0;
  localparam logic [3:0] STYLE_SQUARE      = 4'd1;
  localparam logic [3:0] STYLE_CIRCLE      = 4'd2;
  localparam logic [3:0] STYLE_DECIMAL     = 4'd3;
  localparam logic [3:0] STYLE_LOWER_ALPHA = 4'd4;
  localparam logic [3:0] STYLE_UPPER_ALPHA = 4'd5;
  localparam logic [3:0] STYLE_LOWER_ROMAN = 4'd6;
  localparam logic [3:0] STYLE_UPPER_ROMAN = 4'd7;

  // Roman ranges, exclusive upper bounds
  localparam logic signed [15:0] ROMAN_LOWER_LIMIT = 16'sd3000;
  localparam logic signed [15:0] ROMAN_UPPER_LIMIT = 16'sd20000;

  // code points
  localparam logic [15:0] CP_DISC    = 16'h2022;
  localparam logic [15:0] CP_SQUARE  = 16'h25AA;
  localparam logic [15:0] CP_CIRCLE  = 16'h25E6;
  localparam logic [15:0] CP_MINUS   = 16'h2212;
  localparam logic [15:0] CP_PERIOD  = 16'h002E;
  localparam logic [15:0] CP_AT      = 16'h0040;
  localparam logic [15:0] CP_ZERO    = 16'h0030;
  localparam logic [15:0] CP_UPPER_A = 16'h0041;
  localparam logic [15:0] CP_LOWER_A = 16'h0061;
  localparam logic [15:0] CP_LPAREN  = 16'h0028;
  localparam logic [15:0] CP_RPAREN  = 16'h0029;
  localparam logic [15:0] CP_BAR     = 16'h007C;
  localparam logic [15:0] CP_I       = 16'h0049;
  localparam logic [15:0] CP_V       = 16'h0056;
  localparam logic [15:0] CP_X       = 16'h0058;
  localparam logic [15:0] CP_L       = 16'h004C;
  localparam logic [15:0] CP_C       = 16'h0043;
  localparam logic [15:0] CP_D       = 16'h0044;
  localparam logic [15:0] CP_M       = 16'h004D;
  localparam logic [15:0] CASE_BIT   = 16'h0020;

  // digit extraction: divide by 10 or 26 via reciprocal multiply
  localparam int          NUM_DIGITS = 5;
  localparam logic [15:0] RECIP10    = 16'hCCCD;
  localparam int          SHIFT10    = 19;
  localparam logic [15:0] RECIP26    = 16'h9D8A;
  localparam int          SHIFT26    = 20;
  localparam logic [2:0]  TOP_PLACE  = 3'(NUM_DIGITS - 1);

  typedef enum logic [1:0] {
    KIND_BULLET,
    KIND_DEC,
    KIND_ALPHA,
    KIND_ROMAN
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic        upper;
    logic        neg;
    logic [15:0] mag;
    logic [15:0] glyph;
  } job_t;

  // characters produced by one decimal place of a Roman numeral
  function automatic logic [2:0] roman_len(input logic [2:0] place, input logic [4:0] dg);
    logic [2:0] len;
    if (place == 3'd4) begin
      len = (dg != 5'd0) ? 3'd5 : 3'd0;
    end else if (place == 3'd3) begin
      len = (dg >= 5'd5) ? 3'(dg - 5'd2) : 3'(dg);
    end else if (dg == 5'd9) begin
      len = 3'd2;
    end else if (dg >= 5'd5) begin
      len = 3'(dg - 5'd4);
    end else if (dg == 5'd4) begin
      len = 3'd2;
    end else begin
      len = 3'(dg);
    end
    return len;
  endfunction

  // character k of one Roman place
  function automatic logic [15:0] roman_char(input logic [2:0] place, input logic [4:0] dg,
                                             input logic [2:0] k, input logic upper);
    logic [15:0] cs;
    logic [15:0] one;
    logic [15:0] five;
    logic [15:0] ten;
    logic [15:0] ch;
    cs = upper ? 16'h0000 : CASE_BIT;
    case (place)
      3'd2: begin
        one = CP_C | cs; five = CP_D | cs; ten = CP_M | cs;
      end
      3'd1: begin
        one = CP_X | cs; five = CP_L | cs; ten = CP_C | cs;
      end
      default: begin
        one = CP_I | cs; five = CP_V | cs; ten = CP_X | cs;
      end
    endcase
    if (place == 3'd4) begin
      // ten thousand: ((|))
      if (k < 3'd2) ch = CP_LPAREN;
      else if (k == 3'd2) ch = CP_BAR;
      else ch = CP_RPAREN;
    end else if (place == 3'd3) begin
      // five thousand is |)) then extra M
      if (dg >= 5'd5 && k == 3'd0) ch = CP_BAR;
      else if (dg >= 5'd5 && k < 3'd3) ch = CP_RPAREN;
      else ch = CP_M | cs;
    end else if (dg == 5'd9) begin
      ch = (k == 3'd0) ? one : ten;
    end else if (dg >= 5'd5) begin
      ch = (k == 3'd0) ? five : one;
    end else if (dg == 5'd4) begin
      ch = (k == 3'd0) ? one : five;
    end else begin
      ch = one;
    end
    return ch;
  endfunction

endpackage

FILE: rtl/lmnf_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats and classifies them into jobs.
// Uses lmnf_pkg; feeds lmnf_queue.
module lmnf_front import lmnf_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  marker_style,
  input  logic [15:0] list_number,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic              neg;
  logic [15:0]       mag;
  logic              has_marker;
  logic signed [15:0] num;

  assign num      = list_number;
  assign neg      = list_number[15];
  assign mag      = neg ? (16'd0 - list_number) : list_number;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && has_marker;

  always_comb begin
    has_marker     = 1'b1;
    push_job.kind  = KIND_DEC;
    push_job.upper = 1'b0;
    push_job.neg   = neg;
    push_job.mag   = mag;
    push_job.glyph = CP_DISC;
    unique case (marker_style)
      STYLE_DISC: begin
        push_job.kind = KIND_BULLET;
        push_job.neg  = 1'b0;
      end
      STYLE_SQUARE: begin
        push_job.kind  = KIND_BULLET;
        push_job.neg   = 1'b0;
        push_job.glyph = CP_SQUARE;
      end
      STYLE_CIRCLE: begin
        push_job.kind  = KIND_BULLET;
        push_job.neg   = 1'b0;
        push_job.glyph = CP_CIRCLE;
      end
      STYLE_DECIMAL: begin
        push_job.kind = KIND_DEC;
      end
      STYLE_LOWER_ALPHA: begin
        push_job.kind = KIND_ALPHA;
      end
      STYLE_UPPER_ALPHA: begin
        push_job.kind  = KIND_ALPHA;
        push_job.upper = 1'b1;
      end
      STYLE_LOWER_ROMAN: begin
        if (num > 16'sd0 && num < ROMAN_LOWER_LIMIT) push_job.kind = KIND_ROMAN;
      end
      STYLE_UPPER_ROMAN: begin
        push_job.upper = 1'b1;
        if (num > 16'sd0 && num < ROMAN_UPPER_LIMIT) push_job.kind = KIND_ROMAN;
      end
      default: begin
        has_marker = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/lmnf_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Uses lmnf_pkg for the job record.
module lmnf_queue import lmnf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic not_empty,
  output logic full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

FILE: rtl/lmnf_back.sv
`timescale 1ns / 1ps
// Back end: extracts digits one per cycle, then emits one character per beat.
// Uses lmnf_pkg; takes jobs from lmnf_queue.
module lmnf_back import lmnf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_point,
  output logic        last_char
);

  back_state_t state;
  back_state_t state_next;

  // job context
  kind_t       kind;
  logic        upper;
  logic        sign_pend;
  logic        zero_at;
  logic [15:0] glyph;
  logic        body;
  logic [2:0]  place;
  logic [2:0]  run;
  logic [15:0] val;
  logic [4:0]  digs [NUM_DIGITS];
  logic [2:0]  ndig;

  // divider datapath
  logic        is_alpha;
  logic [15:0] div_in;
  logic [31:0] prod;
  logic [15:0] quo;
  logic [15:0] rem_full;
  logic [4:0]  rem;

  // emit datapath
  logic [4:0]  cur_dig;
  logic [2:0]  body_len;
  logic [15:0] body_char;
  logic        can_emit;
  logic        emit;
  logic [15:0] emit_char;
  logic        emit_last;
  logic        take_sign;
  logic        take_body;
  logic        take_final;
  logic        direct_emit;

  assign is_alpha = (kind == KIND_ALPHA);
  assign div_in   = is_alpha ? val - 16'd1 : val;
  assign prod     = 32'(div_in) * 32'(is_alpha ? RECIP26 : RECIP10);
  assign quo      = is_alpha ? 16'(prod >> SHIFT26) : 16'(prod >> SHIFT10);
  assign rem_full = div_in - (is_alpha ? 16'(quo * 16'd26) : 16'(quo * 16'd10));
  assign rem      = rem_full[4:0];

  assign cur_dig  = digs[place];
  assign body_len = (kind == KIND_ROMAN) ? roman_len(place, cur_dig) : 3'd1;
  assign can_emit = !out_valid || !out_stall;
  assign direct_emit = (q_job.kind == KIND_BULLET) ||
                       (q_job.kind == KIND_ALPHA && q_job.mag == 16'd0);

  always_comb begin
    unique case (kind)
      KIND_ROMAN: body_char = roman_char(place, cur_dig, run, upper);
      KIND_ALPHA: body_char = zero_at ? CP_AT
                                      : (upper ? CP_UPPER_A : CP_LOWER_A) + 16'(cur_dig);
      default:    body_char = CP_ZERO + 16'(cur_dig);
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_char  = CP_PERIOD;
    emit_last  = 1'b0;
    take_sign  = 1'b0;
    take_body  = 1'b0;
    take_final = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_CONV: ;
      BK_EMIT: begin
        if (sign_pend) begin
          emit_char = CP_MINUS;
          emit      = can_emit;
          take_sign = can_emit;
        end else if (body) begin
          emit_char = body_char;
          emit      = can_emit && (body_len != 3'd0);
          // an empty Roman place is skipped without a beat
          take_body = can_emit || (body_len == 3'd0);
        end else begin
          emit_char  = (kind == KIND_BULLET) ? glyph : CP_PERIOD;
          emit_last  = 1'b1;
          emit       = can_emit;
          take_final = can_emit;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = direct_emit ? BK_EMIT : BK_CONV;
      BK_CONV: if (quo == 16'd0) state_next = BK_EMIT;
      BK_EMIT: if (take_final) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_point <= emit_char;
      last_char  <= emit_last;
    end
    if (q_pop) begin
      kind      <= q_job.kind;
      upper     <= q_job.upper;
      sign_pend <= q_job.neg;
      glyph     <= q_job.glyph;
      val       <= q_job.mag;
      zero_at   <= (q_job.kind == KIND_ALPHA) && (q_job.mag == 16'd0);
      body      <= (q_job.kind == KIND_ALPHA) && (q_job.mag == 16'd0);
      ndig      <= 3'd0;
      place     <= 3'd0;
      run       <= 3'd0;
      for (int i = 0; i < NUM_DIGITS; i++) digs[i] <= 5'd0;
    end
    if (state == BK_CONV) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (ndig == 3'(i)) digs[i] <= rem;
      end
      val  <= quo;
      ndig <= ndig + 3'd1;
      if (quo == 16'd0) begin
        body  <= 1'b1;
        place <= (kind == KIND_ROMAN) ? TOP_PLACE : ndig;
        run   <= 3'd0;
      end
    end
    if (take_sign) sign_pend <= 1'b0;
    if (take_body) begin
      if (body_len == 3'd0 || run == body_len - 3'd1) begin
        run <= 3'd0;
        if (place == 3'd0) body <= 1'b0;
        else place <= place - 3'd1;
      end else begin
        run <= run + 3'd1;
      end
    end
  end

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CONV) |-> (ndig < 3'(NUM_DIGITS)))
    else $error("digit extraction ran past five digits");
  a_place_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT && body) |-> (place <= TOP_PLACE))
    else $error("emit place out of range");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == BK_IDLE))
    else $error("sequencer did not return to idle after last beat");

endmodule

FILE: rtl/list_marker_numeral_formatter.sv
`timescale 1ns / 1ps
// List marker numeral formatter, top level.
// Depends on lmnf_pkg, lmnf_front, lmnf_queue and lmnf_back.
//
// Input channel: one beat carries marker_style and a signed list_number.
// It is taken when in_valid is high and in_stall is low. Style none (and the
// unused style codes) is taken and dropped without producing anything.
// Output channel: one beat per marker character, code_point with last_char
// set on the final character; taken when out_valid is high and out_stall low.
// Bullets give one glyph; decimal gives minus, digits, period; alpha uses
// bijective base 26 ('@' for zero); Roman uses apostrophus forms and falls
// back to decimal outside its range.
// Timing: the front classifies in the accepting cycle and writes a job to a
// QUEUE_DEPTH-entry queue, so up to that many items are taken while the back
// end is busy. The back end pops a job, divides by 10 or 26 once per cycle
// through a reciprocal multiplier (up to 5 digits), then emits one character
// per cycle while out_stall is low; an empty Roman place is skipped without
// a beat. The back end takes the next job only after the last character of
// the current one. The longest marker is upper Roman 18888: 5 digits, 24
// characters.
// Reset empties the queue and the output register. A stalled receiver
// holds the current character in the output register; the back end waits,
// and once the queue fills in_stall rises.
module list_marker_numeral_formatter import lmnf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  marker_style,
  input  logic [15:0] list_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_point,
  output logic        last_char
);

  logic push;
  job_t push_job;
  logic pop;
  job_t pop_job;
  logic q_valid;
  logic q_full;

  lmnf_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .marker_style (marker_style),
    .list_number  (list_number),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  lmnf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (q_valid),
    .full      (q_full)
  );

  lmnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .last_char  (last_char)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for list_marker_numeral_formatter.
// Depends on lmnf_pkg and the RTL of the block. It predicts every marker
// character in a scoreboard class and checks each output beat in order.
module testbench;
  import lmnf_pkg::*;

  // Style code that asks for no marker at all; codes 9..15 act the same.
  localparam logic [3:0] STYLE_NONE   = 4'd8;
  localparam int         ITEM_COUNT   = 460;
  localparam int         MAX_WAIT     = 16;
  // Idle margin after the last expected character has come out.
  localparam int         DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] cp;
    logic        last;
  } marker_char_t;

  // Marker predictor and expected-character store.
  class marker_scoreboard;
    marker_char_t pending[$];
    logic [15:0]  staged[$];
    int           errors;

    // Optional minus sign, then the decimal digits of the magnitude.
    function void add_decimal(logic signed [15:0] num);
      int          v;
      logic [15:0] digs[$];
      v = (num < 0) ? -int'(num) : int'(num);
      if (num < 0) staged.push_back(CP_MINUS);
      do begin
        digs.push_front(CP_ZERO + 16'(v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (digs[i]) staged.push_back(digs[i]);
    endfunction

    // One decimal place of a Roman numeral.
    function void add_roman_place(int dg, logic [15:0] one, logic [15:0] five,
                                  logic [15:0] ten);
      if (dg == 9) begin
        staged.push_back(one);
        staged.push_back(ten);
      end else if (dg >= 5) begin
        staged.push_back(five);
        repeat (dg - 5) staged.push_back(one);
      end else if (dg == 4) begin
        staged.push_back(one);
        staged.push_back(five);
      end else begin
        repeat (dg) staged.push_back(one);
      end
    endfunction

    // Work out the marker for one accepted input beat and queue it.
    function void note_item(logic [3:0] style, logic signed [15:0] num);
      int          mag;
      int          v;
      int          th;
      logic [15:0] cs;
      logic [15:0] letters[$];
      logic        in_range;
      mag = (num < 0) ? -int'(num) : int'(num);
      cs = (style == STYLE_UPPER_ALPHA || style == STYLE_UPPER_ROMAN) ? 16'h0000 : CASE_BIT;
      staged.delete();
      case (style)
        STYLE_DISC:   staged.push_back(CP_DISC);
        STYLE_SQUARE: staged.push_back(CP_SQUARE);
        STYLE_CIRCLE: staged.push_back(CP_CIRCLE);
        STYLE_DECIMAL: begin
          add_decimal(num);
          staged.push_back(CP_PERIOD);
        end
        STYLE_LOWER_ALPHA, STYLE_UPPER_ALPHA: begin
          // bijective base 26: a = 1, z = 26, aa = 27; zero shows as '@'
          if (num < 0) staged.push_back(CP_MINUS);
          if (mag == 0) begin
            staged.push_back(CP_AT);
          end else begin
            v = mag;
            while (v != 0) begin
              v = v - 1;
              letters.push_front((CP_UPPER_A | cs) + 16'(v % 26));
              v = v / 26;
            end
            foreach (letters[i]) staged.push_back(letters[i]);
          end
          staged.push_back(CP_PERIOD);
        end
        STYLE_LOWER_ROMAN, STYLE_UPPER_ROMAN: begin
          if (style == STYLE_UPPER_ROMAN) in_range = num > 0 && num < ROMAN_UPPER_LIMIT;
          else in_range = num > 0 && num < ROMAN_LOWER_LIMIT;
          if (in_range) begin
            // apostrophus: ten thousand is ((|)), five thousand is |))
            if (mag >= 10000) begin
              staged.push_back(CP_LPAREN);
              staged.push_back(CP_LPAREN);
              staged.push_back(CP_BAR);
              staged.push_back(CP_RPAREN);
              staged.push_back(CP_RPAREN);
            end
            th = (mag % 10000) / 1000;
            if (th >= 5) begin
              staged.push_back(CP_BAR);
              staged.push_back(CP_RPAREN);
              staged.push_back(CP_RPAREN);
              th = th - 5;
            end
            repeat (th) staged.push_back(CP_M | cs);
            add_roman_place((mag % 1000) / 100, CP_C | cs, CP_D | cs, CP_M | cs);
            add_roman_place((mag % 100) / 10, CP_X | cs, CP_L | cs, CP_C | cs);
            add_roman_place(mag % 10, CP_I | cs, CP_V | cs, CP_X | cs);
          end else begin
            add_decimal(num);
          end
          staged.push_back(CP_PERIOD);
        end
        default: ;
      endcase
      foreach (staged[i]) pending.push_back('{staged[i], i == staged.size() - 1});
    endfunction

    function void check_beat(logic [15:0] cp, logic last);
      marker_char_t want;
      if (pending.size() == 0) begin
        $error("unexpected beat: code_point %h last_char %b", cp, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (cp !== want.cp) begin
        $error("code_point: expected %h, got %h", want.cp, cp);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  marker_style;
  logic [15:0] list_number;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] code_point;
  logic        last_char;

  // When set, neither side inserts gaps or stalls.
  bit calm;

  marker_scoreboard sb = new;

  list_marker_numeral_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .marker_style (marker_style),
    .list_number  (list_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .last_char    (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one beat after a random gap and hold it until taken. Valid is
  // only lowered when a gap is drawn, so a back-to-back beat keeps it high.
  task automatic send_marker(input logic [3:0] style, input logic [15:0] num);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    marker_style <= style;
    list_number  <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(style, num);
  endtask

  // Stop sending and let every expected character come out.
  task automatic drain_markers();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles, then take one beat.
  initial begin
    int hold;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Every beat taken at an edge goes to the scoreboard.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_beat(code_point, last_char);
    end
  end

  // Stimulus and final verdict.
  initial begin
    logic [3:0]  dir_style[25];
    int          dir_num[25];
    int          corner_nums[14];
    int          sent;
    int          pick;
    logic [3:0]  style;
    logic [15:0] num;
    bit          paused;

    // Directed: bullets, decimal extremes including the most negative
    // value, alpha zero and carries, Roman bounds and thousands forms,
    // the fallback to decimal, and styles that give nothing.
    dir_style = '{
      STYLE_DISC, STYLE_SQUARE, STYLE_CIRCLE,
      STYLE_DECIMAL, STYLE_DECIMAL, STYLE_DECIMAL,
      STYLE_LOWER_ALPHA, STYLE_LOWER_ALPHA, STYLE_LOWER_ALPHA,
      STYLE_UPPER_ALPHA, STYLE_UPPER_ALPHA,
      STYLE_LOWER_ROMAN, STYLE_LOWER_ROMAN, STYLE_LOWER_ROMAN, STYLE_LOWER_ROMAN,
      STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN,
      STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN, STYLE_UPPER_ROMAN,
      STYLE_NONE, 4'hF
    };
    dir_num = '{
      1, -1, 0,
      0, 32767, -32768,
      0, 27, -702,
      0, 32767,
      1, 2999, 3000, -4,
      19999, 18888, 10000, 5000, 9494, 4000, 20000, 0,
      5, -32768
    };
    corner_nums = '{
      0, 1, -1, 26, 27, 702, 703, 2999, 3000, 10000, 19999, 20000, 32767, -32768
    };

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    marker_style <= '0;
    list_number  <= '0;
    out_stall    <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_style[i]) send_marker(dir_style[i], 16'(dir_num[i]));
    // Let the block run dry before the random part starts.
    drain_markers();

    sent   = 0;
    paused = 1'b0;
    while (sent < ITEM_COUNT) begin
      // switch between busy stretches and stretches with no idling
      if (sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (sent == ITEM_COUNT / 2 && !paused) begin
        paused = 1'b1;
        drain_markers();
      end
      if ($urandom_range(0, 11) == 0) style = 4'($urandom_range(STYLE_NONE, 15));
      else style = 4'($urandom_range(STYLE_DISC, STYLE_UPPER_ROMAN));
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        num = 16'($urandom);
      end else if (pick == 2) begin
        num = 16'(corner_nums[$urandom_range(0, 13)]);
      end else begin
        // mostly values that each style formats natively
        case (style)
          STYLE_LOWER_ROMAN: num = 16'($urandom_range(1, 2999));
          STYLE_UPPER_ROMAN: num = 16'($urandom_range(1, 19999));
          STYLE_LOWER_ALPHA, STYLE_UPPER_ALPHA: begin
            num = 16'($urandom_range(0, 1000));
            if ($urandom_range(0, 3) == 0) num = -num;
          end
          STYLE_DECIMAL: begin
            num = 16'($urandom_range(0, 20000));
            if ($urandom_range(0, 2) == 0) num = -num;
          end
          default: num = 16'($urandom);
        endcase
      end
      send_marker(style, num);
      sent++;
    end
    calm = 1'b0;
    drain_markers();

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

endmodule
